@@ sv/sawc_pkg.sv @@
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared types and codes for the set-associative write-back cache tag store.
// ----------------------------------------------------------------------------
package sawc_pkg;

    typedef enum logic [1:0] {
        ACT_READ      = 2'd0,
        ACT_STORE     = 2'd1,
        ACT_WRITEBACK = 2'd2,
        ACT_RSVD      = 2'd3
    } t_action;

    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_INDEX  = 2'd1;
    localparam logic [1:0] CFG_WAYS   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

@@ sv/sawc_ram.sv @@
// ----------------------------------------------------------------------------
// sawc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sawc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/set_assoc_writeback_cache_tags_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags_top
// Tag store of one set-associative, write-back, write-allocate cache level.
// ----------------------------------------------------------------------------
// The whole set (all ways, one row of the set memory) is read at the edge
// that takes start. In the following cycle the ways are compared, the
// victim chosen and the row written back, and the result is registered
// and driven for the next cycle with o_valid. busy is high for that one
// lookup cycle, so no new access is taken while a lookup is in progress
// and the read of a set always sees the previous write. The result cannot
// be stalled. After reset a clearing pass writes every set row, with busy
// high.
module set_assoc_writeback_cache_tags_top #(
    parameter int MAX_SETS   = 1024,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_WIDTH-1:0] i_access_addr,
    input  logic [1:0]            i_action,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [3:0]            i_cfg_data,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_fetch_request,
    output logic [ADDR_WIDTH-1:0] o_fetch_addr,
    output logic                  o_evict_writeback,
    output logic [ADDR_WIDTH-1:0] o_evict_addr
);
    import sawc_pkg::*;

    localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IMAX = $clog2(MAX_SETS + 1) - 1;   // floor log2
    localparam int AW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TW   = ADDR_WIDTH - 2;
    localparam int LW   = 2 + TW + AW;               // valid, dirty, tag, age
    localparam int RW   = LW * MAX_WAYS;

    t_state r_state, n_state;
    logic [3:0] r_off, r_idx, r_ways;
    logic [SW-1:0] r_clr, n_clr;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [1:0] r_act;

    logic [3:0] w_off, w_idx, w_ways;
    logic [4:0] w_split;
    logic [SW-1:0] w_set_in, w_set;
    logic [ADDR_WIDTH-1:0] w_tag;
    logic [RW-1:0] w_rdata, w_wdata;
    logic w_we;
    logic [SW-1:0] w_waddr;

    // clamp configuration
    always_comb begin
        w_off = (r_off < 4'd2) ? 4'd2 : ((r_off > 4'd12) ? 4'd12 : r_off);
        w_idx = (int'(r_idx) > IMAX) ? 4'(IMAX) : r_idx;
        w_ways = (r_ways < 4'd1) ? 4'd1 :
                 ((int'(r_ways) > MAX_WAYS) ? 4'(MAX_WAYS) : r_ways);
    end

    // tag shift: offset plus index, may exceed 15
    assign w_split = {1'b0, w_off} + {1'b0, w_idx};

    function automatic logic [SW-1:0] set_of(input logic [ADDR_WIDTH-1:0] a,
                                             input logic [3:0] off,
                                             input logic [3:0] idx);
        logic [ADDR_WIDTH-1:0] m;
        m = (a >> off) & ((ADDR_WIDTH'(1) << idx) - ADDR_WIDTH'(1));
        return m[SW-1:0];
    endfunction

    assign w_set_in = set_of(i_access_addr, w_off, w_idx);
    assign w_set    = set_of(r_addr, w_off, w_idx);
    assign w_tag    = r_addr >> w_split;

    sawc_ram #(.WIDTH(RW), .DEPTH(MAX_SETS)) u_sets (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_set_in),
        .o_rdata(w_rdata)
    );

    // compare, pick victim, update ages
    logic w_hit, w_inv, w_evict, w_wr;
    logic [AW-1:0] w_way, w_inv_way, w_old_way, w_hit_way;
    logic [AW-1:0] w_best;
    logic [ADDR_WIDTH-1:0] w_eaddr;
    always_comb begin
        logic v, d;
        logic [TW-1:0] t;
        logic [AW-1:0] g;
        w_wr = (r_act == ACT_STORE) || (r_act == ACT_WRITEBACK);
        w_hit = 1'b0; w_hit_way = '0;
        w_inv = 1'b0; w_inv_way = '0;
        w_best = '0; w_old_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            v = w_rdata[i*LW + LW - 1];
            t = w_rdata[i*LW + AW +: TW];
            if (i < int'(w_ways) && v && ADDR_WIDTH'(t) == w_tag) begin
                w_hit = 1'b1; w_hit_way = AW'(i);
            end
            if (i < int'(w_ways) && !v) begin
                w_inv = 1'b1; w_inv_way = AW'(i);
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            g = w_rdata[i*LW +: AW];
            if (i < int'(w_ways) && g >= w_best) begin
                w_best = g; w_old_way = AW'(i);
            end
        end
        w_way = w_hit ? w_hit_way : (w_inv ? w_inv_way : w_old_way);
        d = w_rdata[int'(w_way)*LW + LW - 2];
        t = w_rdata[int'(w_way)*LW + AW +: TW];
        w_evict = !w_hit && !w_inv && d;
        w_eaddr = (ADDR_WIDTH'(t) << w_split) |
                  (ADDR_WIDTH'(w_set) << w_off);
        w_wdata = w_rdata;
        for (int i = 0; i < MAX_WAYS; i++) begin
            v = w_rdata[i*LW + LW - 1];
            g = w_rdata[i*LW +: AW];
            if (i < int'(w_ways)) begin
                if (AW'(i) == w_way) begin
                    w_wdata[i*LW +: AW] = '0;
                    if (w_hit) begin
                        if (w_wr) w_wdata[i*LW + LW - 2] = 1'b1;
                    end else begin
                        w_wdata[i*LW + LW - 1] = 1'b1;
                        w_wdata[i*LW + LW - 2] = w_wr;
                        w_wdata[i*LW + AW +: TW] = w_tag[TW-1:0];
                    end
                end else if (v && int'(g) < int'(w_ways) - 1) begin
                    w_wdata[i*LW +: AW] = g + 1'b1;
                end
            end
        end
        if (r_state == ST_CLEAR) w_wdata = '0;
    end

    assign w_we    = (r_state == ST_CLEAR) || (r_state == ST_LOOKUP);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr : w_set;

    // next state
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (int'(r_clr) == MAX_SETS - 1) n_state = ST_IDLE;
            end
            ST_IDLE:   if (start) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end
    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_off   <= 4'd5;
            r_idx   <= 4'd4;
            r_ways  <= 4'd4;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            o_valid <= (r_state == ST_LOOKUP);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OFFSET: r_off  <= i_cfg_data;
                    CFG_INDEX:  r_idx  <= i_cfg_data;
                    CFG_WAYS:   r_ways <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // hold access, register result
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_addr <= i_access_addr;
            r_act  <= i_action;
        end
        if (r_state == ST_LOOKUP) begin
            o_hit             <= w_hit;
            o_fetch_request   <= !w_hit && (r_act != ACT_WRITEBACK);
            o_fetch_addr      <= (!w_hit && r_act != ACT_WRITEBACK) ? r_addr : '0;
            o_evict_writeback <= w_evict;
            o_evict_addr      <= w_evict ? w_eaddr : '0;
        end
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative write-back cache tag store.
// Drives accesses and register writes through the command and write ports.
// A scoreboard class holds a model of the tag store. It predicts each result
// and compares the strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import sawc_pkg::*;

    localparam int SETS_MAX  = 1024;
    localparam int WAYS_MAX  = 8;
    localparam int IDX_CAP   = 10;
    localparam int WDOG_MAX  = 6000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        hit;
        logic        fetch;
        logic [31:0] fetch_addr;
        logic        evict;
        logic [31:0] victim_addr;
    } t_outcome;

    // ------------------------------------------------------------------------
    // Tag store model and queue of predicted outcomes
    // ------------------------------------------------------------------------
    class tag_scoreboard;
        logic        valid_q [SETS_MAX*WAYS_MAX];
        logic        dirty_q [SETS_MAX*WAYS_MAX];
        logic [31:0] tag_q   [SETS_MAX*WAYS_MAX];
        logic [2:0]  age_q   [SETS_MAX*WAYS_MAX];
        logic [3:0]  offset_reg, index_reg, ways_reg;
        t_outcome    predicted [$];
        int          errors;

        function void clear_store();
            for (int i = 0; i < SETS_MAX*WAYS_MAX; i++) begin
                valid_q[i] = 1'b0;
                dirty_q[i] = 1'b0;
                tag_q[i]   = '0;
                age_q[i]   = '0;
            end
            offset_reg = 4'd5;
            index_reg  = 4'd4;
            ways_reg   = 4'd4;
            errors     = 0;
        endfunction

        function int eff_offset();
            if (offset_reg < 2) return 2;
            if (offset_reg > 12) return 12;
            return offset_reg;
        endfunction

        function int eff_index();
            return (index_reg > IDX_CAP) ? IDX_CAP : index_reg;
        endfunction

        function int eff_ways();
            if (ways_reg < 1) return 1;
            if (ways_reg > WAYS_MAX) return WAYS_MAX;
            return ways_reg;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            case (idx)
                CFG_OFFSET: offset_reg = data;
                CFG_INDEX:  index_reg  = data;
                CFG_WAYS:   ways_reg   = data;
                default: ;
            endcase
        endfunction

        // Make one way youngest and age the other valid ways, saturating
        function void touch(int base, int ways, int way);
            for (int i = 0; i < ways; i++) begin
                if (valid_q[base+i] && i != way && age_q[base+i] < ways - 1)
                    age_q[base+i] = age_q[base+i] + 3'd1;
            end
            age_q[base+way] = 3'd0;
        endfunction

        // Predict the outcome of one accepted access and update the model
        function void note_access(logic [31:0] addr, logic [1:0] act);
            t_outcome    res;
            logic        wb_in, wr_like, hit, found_inv;
            int          off, idx, ways, base, way, best;
            logic [31:0] set_no, tag;
            wb_in    = (act == ACT_WRITEBACK);
            wr_like  = (act == ACT_STORE) || wb_in;
            off      = eff_offset();
            idx      = eff_index();
            ways     = eff_ways();
            set_no   = (addr >> off) & ((32'd1 << idx) - 32'd1);
            tag      = addr >> (off + idx);
            base     = set_no * WAYS_MAX;
            hit      = 1'b0;
            found_inv = 1'b0;
            way      = 0;
            best     = 0;
            res      = '0;
            for (int i = 0; i < ways; i++) begin
                if (!hit && valid_q[base+i] && tag_q[base+i] == tag) begin
                    hit = 1'b1;
                    way = i;
                end
            end
            if (hit) begin
                touch(base, ways, way);
                if (wr_like) dirty_q[base+way] = 1'b1;
            end else begin
                res.fetch = !wb_in;
                for (int i = 0; i < ways; i++) begin
                    if (!found_inv) begin
                        if (!valid_q[base+i]) begin
                            way = i;
                            found_inv = 1'b1;
                        end else if (age_q[base+i] >= best) begin
                            best = age_q[base+i];
                            way = i;
                        end
                    end
                end
                if (!found_inv && dirty_q[base+way]) begin
                    res.evict       = 1'b1;
                    res.victim_addr = (tag_q[base+way] << (off + idx)) | (set_no << off);
                end
                valid_q[base+way] = 1'b1;
                dirty_q[base+way] = wr_like;
                tag_q[base+way]   = tag;
                touch(base, ways, way);
            end
            res.hit        = hit;
            res.fetch_addr = res.fetch ? addr : 32'd0;
            predicted.insert(predicted.size(), res);
        endfunction

        // Compare one strobed result with the oldest prediction
        function void check_result(t_outcome got);
            t_outcome exp_r;
            if (predicted.size() == 0) begin
                $error("unexpected result: no access outstanding");
                errors++;
                return;
            end
            exp_r = predicted.pop_front();
            if (got.hit !== exp_r.hit) begin
                $error("hit: expected %0d, actual %0d", exp_r.hit, got.hit);
                errors++;
            end
            if (got.fetch !== exp_r.fetch) begin
                $error("fetch_request: expected %0d, actual %0d", exp_r.fetch, got.fetch);
                errors++;
            end
            if (got.fetch_addr !== exp_r.fetch_addr) begin
                $error("fetch_addr: expected %h, actual %h",
                       exp_r.fetch_addr, got.fetch_addr);
                errors++;
            end
            if (got.evict !== exp_r.evict) begin
                $error("evict_writeback: expected %0d, actual %0d", exp_r.evict, got.evict);
                errors++;
            end
            if (got.victim_addr !== exp_r.victim_addr) begin
                $error("o_evict_addr: expected %h, actual %h",
                       exp_r.victim_addr, got.victim_addr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_access_addr;
    logic [1:0]  i_action;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [3:0]  i_cfg_data;
    logic        o_valid;
    logic        o_hit;
    logic        o_fetch_request;
    logic [31:0] o_fetch_addr;
    logic        o_evict_writeback;
    logic [31:0] o_evict_addr;

    tag_scoreboard sb;
    logic [31:0]   tag_pool [8];
    logic          calm;
    int            quiet_cycles;

    set_assoc_writeback_cache_tags_top #(
        .MAX_SETS   (SETS_MAX),
        .MAX_WAYS   (WAYS_MAX),
        .ADDR_WIDTH (32)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_access_addr     (i_access_addr),
        .i_action          (i_action),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_fetch_request   (o_fetch_request),
        .o_fetch_addr      (o_fetch_addr),
        .o_evict_writeback (o_evict_writeback),
        .o_evict_addr      (o_evict_addr)
    );

    // Clock: period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Record accepted transfers, check results, and run the watchdog
    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_access(i_access_addr, i_action);
            end
            if (o_valid) begin
                got.hit         = o_hit;
                got.fetch       = o_fetch_request;
                got.fetch_addr  = o_fetch_addr;
                got.evict       = o_evict_writeback;
                got.victim_addr = o_evict_addr;
                sb.check_result(got);
            end
            if ((start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Issue one access; return after its transfer
    task automatic send_access(logic [31:0] addr, logic [1:0] act);
        while (!calm && $urandom_range(99) < 31) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start         = 1'b1;
        i_access_addr = addr;
        i_action      = act;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Let the block drain, then write one register
    task automatic write_cfg(logic [1:0] idx, logic [3:0] data);
        start = 1'b0;
        while (sb.predicted.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_geometry(logic [3:0] off, logic [3:0] idx, logic [3:0] ways);
        write_cfg(CFG_OFFSET, off);
        write_cfg(CFG_INDEX, idx);
        write_cfg(CFG_WAYS, ways);
        foreach (tag_pool[k]) tag_pool[k] = $urandom;
    endtask

    // Build an address from a small tag pool and a few sets, so lines collide
    function automatic logic [31:0] pick_addr();
        int off, idx;
        logic [31:0] set_no;
        off = sb.eff_offset();
        idx = sb.eff_index();
        if ($urandom_range(9) < 2) return $urandom;
        set_no = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
        set_no = set_no & ((32'd1 << idx) - 32'd1);
        return (tag_pool[$urandom_range(7)] << (off + idx)) | (set_no << off)
               | ($urandom & ((32'd1 << off) - 32'd1));
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 45) return ACT_READ;
        if (r < 75) return ACT_STORE;
        if (r < 95) return ACT_WRITEBACK;
        return ACT_RSVD;
    endfunction

    initial begin
        logic [31:0] a;
        sb = new();
        sb.clear_store();
        foreach (tag_pool[k]) tag_pool[k] = $urandom;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_access_addr = '0;
        i_action      = ACT_READ;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_OFFSET;
        i_cfg_data    = '0;
        calm          = 1'b1;
        quiet_cycles  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default geometry (32-byte lines, 16 sets, 4 ways)
        send_access(32'h0000_0000, ACT_READ);
        send_access(32'h0000_0004, ACT_READ);
        send_access(32'h0000_0008, ACT_STORE);
        send_access(32'hFFFF_FFFF, ACT_WRITEBACK);
        send_access(32'hFFFF_FFE0, ACT_RSVD);
        send_access(32'h0000_0200, ACT_RSVD);
        // fill set 0 with dirty lines, then force dirty evictions
        for (int t = 1; t <= 6; t++)
            send_access(t << 9, (t % 2) ? ACT_STORE : ACT_WRITEBACK);
        send_access(32'h0000_0000, ACT_READ);
        send_access(32'h0000_1E00, ACT_READ);
        send_access(32'h0000_2000, ACT_READ);
        send_access(32'hAAAA_AAAA, ACT_STORE);
        send_access(32'h5555_5555, ACT_WRITEBACK);

        // Directed: out-of-range and unused register values
        write_cfg(CFG_UNUSED, 4'hF);
        set_geometry(4'd0, 4'd15, 4'd0);
        send_access(32'h0000_0010, ACT_STORE);
        send_access(32'h0000_1010, ACT_READ);
        set_geometry(4'd15, 4'd10, 4'd15);
        send_access(32'h0000_0010, ACT_READ);
        send_access(32'h8000_0000, ACT_STORE);
        set_geometry(4'd12, 4'd0, 4'd1);
        send_access(32'h0000_1000, ACT_STORE);
        send_access(32'h0000_2000, ACT_READ);
        set_geometry(4'd2, 4'd10, 4'd8);

        // Random phases: first a run with no gaps, then random gaps
        for (int ph = 0; ph < 12; ph++) begin
            if (ph > 0) begin
                case (ph % 4)
                    0: set_geometry(4'($urandom_range(2, 12)), 4'($urandom_range(0, 10)),
                                    4'($urandom_range(1, 8)));
                    1: set_geometry(4'($urandom_range(2, 6)), 4'($urandom_range(0, 3)),
                                    4'($urandom_range(1, 4)));
                    2: set_geometry(4'($urandom_range(15)), 4'($urandom_range(15)),
                                    4'($urandom_range(15)));
                    default: set_geometry(4'd2, 4'd0, 4'd8);
                endcase
            end
            calm = (ph == 0);
            for (int n = 0; n < 70; n++) begin
                a = pick_addr();
                send_access(a, pick_action());
            end
        end
        start = 1'b0;

        while (sb.predicted.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.predicted.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sawc_pkg.sv
sv/sawc_ram.sv
sv/set_assoc_writeback_cache_tags_top.sv
test/tb.sv
